@@ design/sakj_pkg.sv @@
// Shared types, constants and fixed-point helpers for the arm kinematics block.
// Used by sakj_controller, sakj_datapath and serial_arm_kinematics_jacobian.
`timescale 1ns / 1ps
`default_nettype none

package sakj_pkg;

   localparam int FRAME_COUNT_DEF  = 7;
   localparam int FRAC_BITS_DEF    = 12;
   localparam int CORDIC_STEPS_DEF = 14;
   localparam int ANG_BITS         = 30;
   localparam int STEP_W           = 5;

   localparam logic [2:0] PRISMATIC_FRAME = 3'd2;
   localparam logic [2:0] LAST_FRAME      = 3'd6;

   localparam logic [1:0] CSR_BASE_ROW_ZERO = 2'd0;
   localparam logic [1:0] CSR_BASE_ROW_ONE  = 2'd1;
   localparam logic [1:0] CSR_BASE_ROW_TWO  = 2'd2;

   localparam longint PI_Q          = 64'sd3373259426;
   localparam longint HALF_PI_Q     = 64'sd1686629713;
   localparam longint TWO_PI_Q      = 64'sd6746518852;
   localparam longint CORDIC_GAIN_Q = 64'sd652032874;
   localparam longint LEN_RCC_Q     = 64'sd463641720;
   localparam longint LEN_2L2_Q     = 64'sd554050781;
   localparam longint LEN_P2Y_Q     = 64'sd9771051;
   localparam longint LEN_TOOL_Q    = 64'sd446891347;

   typedef enum logic [3:0] {
      ST_IDLE, ST_TH_LOAD, ST_TH_REDUCE, ST_TH_FOLD, ST_CORDIC, ST_CORDIC_FIN,
      ST_MM_ISSUE, ST_MM_DRAIN, ST_COMMIT, ST_JAC_READ, ST_JAC_DIFF,
      ST_JAC_MUL_A, ST_JAC_MUL_B, ST_JAC_LOAD
   } sakj_state_type;

   typedef struct packed {
      logic              latch;
      logic              th_load;
      logic              th_reduce;
      logic              th_fold;
      logic              cordic_step;
      logic [STEP_W-1:0] step;
      logic              cordic_finish;
      logic              mm_issue;
      logic [1:0]        mm_row;
      logic [1:0]        mm_col;
      logic              commit;
      logic [2:0]        frame;
      logic              jac_read;
      logic              jac_diff;
      logic              jac_mul_a;
      logic              jac_mul_b;
      logic              jac_load;
   } sakj_cmd_type;

   typedef struct packed {
      logic th_in_range;
      logic out_busy;
   } sakj_status_type;

   function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
      if (v > 48'sd32767) return 16'sh7fff;
      else if (v < -48'sd32768) return 16'sh8000;
      else return v[15:0];
   endfunction

   function automatic logic signed [15:0] rnd_sat(input logic signed [47:0] v, input int s);
      logic signed [47:0] r;
      r = (v + (48'sd1 <<< (s - 1))) >>> s;
      return sat16(r);
   endfunction

   function automatic logic signed [15:0] neg_sat(input logic signed [15:0] x);
      return sat16(48'sd0 - 48'(x));
   endfunction

   function automatic logic signed [15:0] sgn_sel(input logic signed [15:0] x,
                                                  input logic signed [1:0] s);
      case (s)
         2'sd1:   return x;
         -2'sd1:  return neg_sat(x);
         default: return 16'sd0;
      endcase
   endfunction

   function automatic logic signed [15:0] len_q(input longint v, input int frac);
      longint r;
      r = (v + (64'sd1 <<< (ANG_BITS - frac - 1))) >>> (ANG_BITS - frac);
      if (r > 32767) r = 32767;
      return 16'(r);
   endfunction

   function automatic logic signed [33:0] theta_off(input logic [2:0] k);
      case (k)
         3'd0, 3'd4, 3'd5: return 34'(HALF_PI_Q);
         3'd1:             return -34'(HALF_PI_Q);
         3'd2, 3'd6:       return 34'(PI_Q);
         default:          return 34'sd0;
      endcase
   endfunction

   function automatic logic signed [1:0] alpha_c(input logic [2:0] k);
      return (k == 3'd3) ? 2'sd1 : 2'sd0;
   endfunction

   function automatic logic signed [1:0] alpha_s(input logic [2:0] k);
      case (k)
         3'd0, 3'd2, 3'd4: return 2'sd1;
         3'd3:             return 2'sd0;
         default:          return -2'sd1;
      endcase
   endfunction

   function automatic logic [29:0] atan_q(input logic [STEP_W-1:0] i);
      case (i)
         5'd0:  return 30'd843314857;
         5'd1:  return 30'd497837829;
         5'd2:  return 30'd263043837;
         5'd3:  return 30'd133525159;
         5'd4:  return 30'd67021687;
         5'd5:  return 30'd33543516;
         5'd6:  return 30'd16775851;
         5'd7:  return 30'd8388437;
         5'd8:  return 30'd4194283;
         5'd9:  return 30'd2097149;
         5'd10: return 30'd1048576;
         5'd11: return 30'd524288;
         5'd12: return 30'd262144;
         5'd13: return 30'd131072;
         5'd14: return 30'd65536;
         5'd15: return 30'd32768;
         5'd16: return 30'd16384;
         5'd17: return 30'd8192;
         5'd18: return 30'd4096;
         5'd19: return 30'd2048;
         5'd20: return 30'd1024;
         5'd21: return 30'd512;
         5'd22: return 30'd256;
         5'd23: return 30'd128;
         default: return 30'd0;
      endcase
   endfunction

endpackage

`default_nettype wire

@@ design/sakj_controller.sv @@
// Sequencer for the arm kinematics block: angle reduction, CORDIC steps,
// matrix product issue and Jacobian output. Depends on sakj_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sakj_controller import sakj_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output sakj_cmd_type         cmd,
   input  wire sakj_status_type status
);

   sakj_state_type    state_ff, state_in;
   logic [2:0]        frame_ff, frame_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [1:0]        row_ff, row_in;
   logic [1:0]        col_ff, col_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         frame_ff <= 3'd0;
         step_ff  <= '0;
         row_ff   <= 2'd0;
         col_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         frame_ff <= frame_in;
         step_ff  <= step_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      frame_in  = frame_ff;
      step_in   = step_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.frame  = frame_ff;
      cmd.step   = step_ff;
      cmd.mm_row = row_ff;
      cmd.mm_col = col_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               frame_in  = 3'd0;
               state_in  = ST_TH_LOAD;
            end
         end
         ST_TH_LOAD: begin
            cmd.th_load = 1'b1;
            state_in    = ST_TH_REDUCE;
         end
         ST_TH_REDUCE: begin
            if (status.th_in_range) begin
               state_in = ST_TH_FOLD;
            end else begin
               cmd.th_reduce = 1'b1;
            end
         end
         ST_TH_FOLD: begin
            cmd.th_fold = 1'b1;
            step_in     = '0;
            state_in    = ST_CORDIC;
         end
         ST_CORDIC: begin
            cmd.cordic_step = 1'b1;
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = ST_CORDIC_FIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_CORDIC_FIN: begin
            cmd.cordic_finish = 1'b1;
            row_in   = 2'd0;
            col_in   = 2'd0;
            state_in = ST_MM_ISSUE;
         end
         ST_MM_ISSUE: begin
            cmd.mm_issue = 1'b1;
            col_in       = col_ff + 1'b1;
            if (col_ff == 2'd3) begin
               row_in = row_ff + 1'b1;
               if (row_ff == 2'd2) begin
                  state_in = ST_MM_DRAIN;
               end
            end
         end
         ST_MM_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            if (frame_ff == LAST_FRAME) begin
               frame_in = 3'd0;
               state_in = ST_JAC_READ;
            end else begin
               frame_in = frame_ff + 1'b1;
               state_in = ST_TH_LOAD;
            end
         end
         ST_JAC_READ: begin
            cmd.jac_read = 1'b1;
            state_in     = ST_JAC_DIFF;
         end
         ST_JAC_DIFF: begin
            cmd.jac_diff = 1'b1;
            state_in     = ST_JAC_MUL_A;
         end
         ST_JAC_MUL_A: begin
            cmd.jac_mul_a = 1'b1;
            state_in      = ST_JAC_MUL_B;
         end
         ST_JAC_MUL_B: begin
            cmd.jac_mul_b = 1'b1;
            state_in      = ST_JAC_LOAD;
         end
         ST_JAC_LOAD: begin
            if (!status.out_busy) begin
               cmd.jac_load = 1'b1;
               if (frame_ff == LAST_FRAME) begin
                  state_in = ST_IDLE;
               end else begin
                  frame_in = frame_ff + 1'b1;
                  state_in = ST_JAC_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ design/sakj_datapath.sv @@
// Datapath of the arm kinematics block: base registers, CORDIC, shared
// multipliers, frame store and result register. Depends on sakj_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sakj_datapath import sakj_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sakj_cmd_type       cmd,
   output sakj_status_type         status,
   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [63:0]        csr_write_data,
   input  wire logic signed [15:0] req_outer_yaw,
   input  wire logic signed [15:0] req_outer_pitch,
   input  wire logic signed [15:0] req_insertion,
   input  wire logic signed [15:0] req_tool_roll,
   input  wire logic signed [15:0] req_wrist_pitch,
   input  wire logic signed [15:0] req_wrist_yaw,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_frame_index,
   output logic [63:0]             rsp_frame_row_zero,
   output logic [63:0]             rsp_frame_row_one,
   output logic [63:0]             rsp_frame_row_two,
   output logic [47:0]             rsp_linear_column,
   output logic [47:0]             rsp_angular_column,
   output logic                    rsp_last_frame
);

   localparam int ANG_SHIFT = ANG_BITS - FRAC_BITS;
   localparam int TH_W = (((ANG_SHIFT + 16) > 33) ? (ANG_SHIFT + 16) : 33) + 2;
   localparam int X_W  = 34;
   localparam logic signed [15:0] ONE_Q =
      (FRAC_BITS >= 15) ? 16'sh7fff : 16'(1 << FRAC_BITS);
   localparam logic signed [15:0] L_2L2  = len_q(LEN_2L2_Q, FRAC_BITS);
   localparam logic signed [15:0] L_RCC  = len_q(LEN_RCC_Q, FRAC_BITS);
   localparam logic signed [15:0] L_TOOL = len_q(LEN_TOOL_Q, FRAC_BITS);
   localparam logic signed [15:0] L_P2Y  = len_q(LEN_P2Y_Q, FRAC_BITS);
   localparam logic signed [TH_W-1:0] PI_T      = TH_W'(PI_Q);
   localparam logic signed [TH_W-1:0] HALF_PI_T = TH_W'(HALF_PI_Q);
   localparam logic signed [TH_W-1:0] TWO_PI_T  = TH_W'(TWO_PI_Q);

   logic [63:0] base_row_ff [3];
   logic signed [15:0] yaw_ff, pitch_ff, ins_ff, roll_ff, wpitch_ff, wyaw_ff;
   logic [2:0][3:0][15:0] prev_ff, tbuf_ff, rd_ff;
   logic [2:0][3:0][15:0] frame_mem [FRAME_COUNT_DEF];
   logic signed [TH_W-1:0] t_ff, t_in;
   logic signed [X_W-1:0] x_ff, y_ff, x_in, y_in, xf, yf;
   logic neg_ff;
   logic signed [15:0] ct_ff, st_ff;
   logic signed [31:0] prod_ff [3];
   logic signed [31:0] hold_ff [3];
   logic signed [15:0] bias_ff;
   logic signed [15:0] dv_ff [3];
   logic mm_wr_valid_ff;
   logic [1:0] wr_row_ff, wr_col_ff;
   logic rsp_valid_ff;
   logic [2:0] rsp_frame_index_ff;
   logic [63:0] rsp_row_ff [3];
   logic [47:0] rsp_lin_ff, rsp_ang_ff;
   logic rsp_last_ff;

   logic signed [15:0] th_sel, d_val, a_val, one_v;
   logic signed [TH_W-1:0] th_start, atan_ext;
   logic signed [15:0] a_mat [3][4];
   logic signed [15:0] op_a [3];
   logic signed [15:0] op_b [3];
   logic signed [15:0] z [3];
   logic signed [15:0] lin [3];
   logic signed [47:0] acc;

   assign one_v = ONE_Q;

   always_comb begin
      case (cmd.frame)
         3'd0:    th_sel = yaw_ff;
         3'd1:    th_sel = pitch_ff;
         3'd3:    th_sel = roll_ff;
         3'd4:    th_sel = wpitch_ff;
         3'd5:    th_sel = wyaw_ff;
         default: th_sel = 16'sd0;
      endcase
      th_start = TH_W'(theta_off(cmd.frame)) + (TH_W'(th_sel) <<< ANG_SHIFT);
      case (cmd.frame)
         3'd0:    d_val = neg_sat(L_2L2);
         3'd2:    d_val = sat16(48'(ins_ff) - 48'(L_RCC));
         3'd3:    d_val = L_TOOL;
         3'd6:    d_val = neg_sat(L_P2Y);
         default: d_val = 16'sd0;
      endcase
      a_val = (cmd.frame == 3'd5) ? L_P2Y : 16'sd0;
      a_mat[0][0] = ct_ff;
      a_mat[0][1] = neg_sat(st_ff);
      a_mat[0][2] = 16'sd0;
      a_mat[0][3] = a_val;
      a_mat[1][0] = sgn_sel(st_ff, alpha_c(cmd.frame));
      a_mat[1][1] = sgn_sel(ct_ff, alpha_c(cmd.frame));
      a_mat[1][2] = sgn_sel(one_v, -alpha_s(cmd.frame));
      a_mat[1][3] = sgn_sel(d_val, -alpha_s(cmd.frame));
      a_mat[2][0] = sgn_sel(st_ff, alpha_s(cmd.frame));
      a_mat[2][1] = sgn_sel(ct_ff, alpha_s(cmd.frame));
      a_mat[2][2] = sgn_sel(one_v, alpha_c(cmd.frame));
      a_mat[2][3] = sgn_sel(d_val, alpha_c(cmd.frame));
   end

   always_comb begin
      atan_ext = TH_W'({1'b0, atan_q(cmd.step)});
      if (t_ff >= 0) begin
         x_in = x_ff - (y_ff >>> cmd.step);
         y_in = y_ff + (x_ff >>> cmd.step);
         t_in = t_ff - atan_ext;
      end else begin
         x_in = x_ff + (y_ff >>> cmd.step);
         y_in = y_ff - (x_ff >>> cmd.step);
         t_in = t_ff + atan_ext;
      end
      xf = neg_ff ? -x_ff : x_ff;
      yf = neg_ff ? -y_ff : y_ff;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         z[i] = $signed(rd_ff[i][2]);
      end
      for (int m = 0; m < 3; m++) begin
         op_a[m] = $signed(prev_ff[cmd.mm_row][m]);
         op_b[m] = a_mat[m][cmd.mm_col];
      end
      if (cmd.jac_mul_a) begin
         op_a[0] = z[1]; op_b[0] = dv_ff[2];
         op_a[1] = z[2]; op_b[1] = dv_ff[0];
         op_a[2] = z[0]; op_b[2] = dv_ff[1];
      end else if (cmd.jac_mul_b) begin
         op_a[0] = z[2]; op_b[0] = dv_ff[1];
         op_a[1] = z[0]; op_b[1] = dv_ff[2];
         op_a[2] = z[1]; op_b[2] = dv_ff[0];
      end
      acc = 48'(prod_ff[0]) + 48'(prod_ff[1]) + 48'(prod_ff[2])
          + (48'(bias_ff) <<< FRAC_BITS);
      for (int i = 0; i < 3; i++) begin
         lin[i] = rnd_sat(48'(hold_ff[i]) - 48'(prod_ff[i]), FRAC_BITS);
      end
   end

   assign status = '{th_in_range: (t_ff < PI_T) && (t_ff >= -PI_T),
                     out_busy:    rsp_valid_ff && !rsp_ready};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            base_row_ff[r] <= {48'd0, ONE_Q} << (16 * r);
         end
         mm_wr_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BASE_ROW_ZERO: base_row_ff[0] <= csr_write_data;
               CSR_BASE_ROW_ONE:  base_row_ff[1] <= csr_write_data;
               CSR_BASE_ROW_TWO:  base_row_ff[2] <= csr_write_data;
               default: ;
            endcase
         end
         mm_wr_valid_ff <= cmd.mm_issue;
         if (cmd.jac_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         yaw_ff    <= req_outer_yaw;
         pitch_ff  <= req_outer_pitch;
         ins_ff    <= req_insertion;
         roll_ff   <= req_tool_roll;
         wpitch_ff <= req_wrist_pitch;
         wyaw_ff   <= req_wrist_yaw;
         for (int i = 0; i < 3; i++) begin
            prev_ff[i] <= base_row_ff[i];
         end
      end else if (cmd.commit) begin
         prev_ff <= tbuf_ff;
      end
      if (cmd.commit) begin
         frame_mem[cmd.frame] <= tbuf_ff;
      end
      if (cmd.jac_read) begin
         rd_ff <= frame_mem[cmd.frame];
      end
      if (cmd.th_load) begin
         t_ff <= th_start;
      end else if (cmd.th_reduce) begin
         t_ff <= (t_ff >= PI_T) ? t_ff - TWO_PI_T : t_ff + TWO_PI_T;
      end else if (cmd.th_fold) begin
         x_ff <= X_W'(CORDIC_GAIN_Q);
         y_ff <= '0;
         if (t_ff > HALF_PI_T) begin
            t_ff   <= t_ff - PI_T;
            neg_ff <= 1'b1;
         end else if (t_ff < -HALF_PI_T) begin
            t_ff   <= t_ff + PI_T;
            neg_ff <= 1'b1;
         end else begin
            neg_ff <= 1'b0;
         end
      end else if (cmd.cordic_step) begin
         t_ff <= t_in;
         x_ff <= x_in;
         y_ff <= y_in;
      end
      if (cmd.cordic_finish) begin
         ct_ff <= rnd_sat(48'(xf), ANG_SHIFT);
         st_ff <= rnd_sat(48'(yf), ANG_SHIFT);
      end
      if (cmd.mm_issue || cmd.jac_mul_a || cmd.jac_mul_b) begin
         for (int m = 0; m < 3; m++) begin
            prod_ff[m] <= op_a[m] * op_b[m];
         end
      end
      if (cmd.jac_mul_b) begin
         hold_ff <= prod_ff;
      end
      bias_ff   <= (cmd.mm_col == 2'd3) ? $signed(prev_ff[cmd.mm_row][3]) : 16'sd0;
      wr_row_ff <= cmd.mm_row;
      wr_col_ff <= cmd.mm_col;
      if (mm_wr_valid_ff) begin
         tbuf_ff[wr_row_ff][wr_col_ff] <= rnd_sat(acc, FRAC_BITS);
      end
      if (cmd.jac_diff) begin
         for (int i = 0; i < 3; i++) begin
            dv_ff[i] <= sat16(48'($signed(prev_ff[i][3])) - 48'($signed(rd_ff[i][3])));
         end
      end
      if (cmd.jac_load) begin
         rsp_frame_index_ff <= cmd.frame;
         for (int i = 0; i < 3; i++) begin
            rsp_row_ff[i] <= rd_ff[i];
         end
         if (cmd.frame == PRISMATIC_FRAME) begin
            rsp_lin_ff <= {z[2], z[1], z[0]};
            rsp_ang_ff <= '0;
         end else begin
            rsp_lin_ff <= {lin[2], lin[1], lin[0]};
            rsp_ang_ff <= {z[2], z[1], z[0]};
         end
         rsp_last_ff <= (cmd.frame == LAST_FRAME);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_index    = rsp_frame_index_ff;
   assign rsp_frame_row_zero = rsp_row_ff[0];
   assign rsp_frame_row_one  = rsp_row_ff[1];
   assign rsp_frame_row_two  = rsp_row_ff[2];
   assign rsp_linear_column  = rsp_lin_ff;
   assign rsp_angular_column = rsp_ang_ff;
   assign rsp_last_frame     = rsp_last_ff;

endmodule

`default_nettype wire

@@ design/serial_arm_kinematics_jacobian.sv @@
// Top level of the arm forward kinematics and Jacobian block.
// Instantiates sakj_controller and sakj_datapath; depends on sakj_pkg.
//
// Usage: one input item carries six joint values (Q3.12). For each item the
// block returns seven result items, frames 0 to 6 in order, each with the
// frame's top three transform rows and its Jacobian column; the seventh has
// last_frame set. Both channels use valid and ready.
// The user must write the base transform through the csr port while the
// block idles; the block itself does not enforce this. Each frame runs
// angle reduction, one CORDIC step a cycle, twelve entries through three
// shared multipliers and a commit; each result then gets a Jacobian pass.
// The single iterative CORDIC and the shared multipliers set the run time.
// One item is processed at a time; req_ready is high while the block idles,
// which includes the time the last result of the previous item still waits.
// A stalled receiver holds the result register and pauses the Jacobian pass.
// Reset returns the sequencer to idle, drops rsp_valid and restores the
// base transform to the identity.
`timescale 1ns / 1ps
`default_nettype none

module serial_arm_kinematics_jacobian import sakj_pkg::*; #(
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [63:0]        csr_write_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_outer_yaw,
   input  wire logic signed [15:0] req_outer_pitch,
   input  wire logic signed [15:0] req_insertion,
   input  wire logic signed [15:0] req_tool_roll,
   input  wire logic signed [15:0] req_wrist_pitch,
   input  wire logic signed [15:0] req_wrist_yaw,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_frame_index,
   output logic [63:0]             rsp_frame_row_zero,
   output logic [63:0]             rsp_frame_row_one,
   output logic [63:0]             rsp_frame_row_two,
   output logic [47:0]             rsp_linear_column,
   output logic [47:0]             rsp_angular_column,
   output logic                    rsp_last_frame
);

   sakj_cmd_type    cmd;
   sakj_status_type status;

   sakj_controller #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   sakj_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_outer_yaw      (req_outer_yaw),
      .req_outer_pitch    (req_outer_pitch),
      .req_insertion      (req_insertion),
      .req_tool_roll      (req_tool_roll),
      .req_wrist_pitch    (req_wrist_pitch),
      .req_wrist_yaw      (req_wrist_yaw),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_index    (rsp_frame_index),
      .rsp_frame_row_zero (rsp_frame_row_zero),
      .rsp_frame_row_one  (rsp_frame_row_one),
      .rsp_frame_row_two  (rsp_frame_row_two),
      .rsp_linear_column  (rsp_linear_column),
      .rsp_angular_column (rsp_angular_column),
      .rsp_last_frame     (rsp_last_frame)
   );

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.jac_load |-> !status.out_busy)
      else $error("result register overwritten while still pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new item taken while a run is in progress");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_frame) |-> (rsp_frame_index == LAST_FRAME))
      else $error("last flag on a frame other than the final one");

   a_prismatic_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_index == PRISMATIC_FRAME) |-> (rsp_angular_column == '0))
      else $error("prismatic frame carries an angular part");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for serial_arm_kinematics_jacobian: joint items in,
// seven frame/Jacobian items out, each predicted in fixed point and compared.
// Depends on sakj_pkg and the RTL of the block.
`timescale 1ns / 1ps

typedef struct packed {
   logic [2:0]  frame;
   logic [63:0] row0, row1, row2;
   logic [47:0] lin, ang;
   logic        last;
} frame_result_type;

class kinematics_scoreboard;
   frame_result_type pending[$];
   logic [63:0] base_rows[3];
   int mismatches;
   int frames_checked;

   function void set_base(int idx, logic [63:0] v);
      if (idx <= 2) base_rows[idx] = v;
   endfunction

   function longint asr(longint v, int s);
      return v >>> s;
   endfunction

   function longint rnd(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function longint sat(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function longint sx(logic [15:0] v);
      return longint'($signed(v));
   endfunction

   function longint arctan_step(int i);
      longint t[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
         33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
         262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
         256, 128};
      return t[i];
   endfunction

   function void sin_cos(longint t, output longint c, output longint s);
      longint x, y, nx;
      bit neg;
      x = sakj_pkg::CORDIC_GAIN_Q;
      y = 0;
      neg = 0;
      while (t >= sakj_pkg::PI_Q) t -= sakj_pkg::TWO_PI_Q;
      while (t < -sakj_pkg::PI_Q) t += sakj_pkg::TWO_PI_Q;
      if (t > sakj_pkg::HALF_PI_Q) begin
         t -= sakj_pkg::PI_Q;
         neg = 1;
      end else if (t < -sakj_pkg::HALF_PI_Q) begin
         t += sakj_pkg::PI_Q;
         neg = 1;
      end
      for (int i = 0; i < 14; i++) begin
         if (t >= 0) begin
            nx = x - asr(y, i); y = y + asr(x, i); t -= arctan_step(i);
         end else begin
            nx = x + asr(y, i); y = y - asr(x, i); t += arctan_step(i);
         end
         x = nx;
      end
      if (neg) begin
         x = -x; y = -y;
      end
      c = sat(rnd(x, 18));
      s = sat(rnd(y, 18));
   endfunction

   function longint link_len(longint v);
      return sat(rnd(v, 18));
   endfunction

   function void note_joints(logic [15:0] j[6]);
      longint tf[7][3][4];
      longint prv[3][4], lk[3][4];
      longint th, ct, st, d, a, ca, sa, acc;
      longint z[3], dv[3], lin[3], ang[3];
      longint off[7];
      int src[7];
      frame_result_type r;
      off = '{sakj_pkg::HALF_PI_Q, -sakj_pkg::HALF_PI_Q, sakj_pkg::PI_Q, 0,
              sakj_pkg::HALF_PI_Q, sakj_pkg::HALF_PI_Q, sakj_pkg::PI_Q};
      src = '{0, 1, -1, 3, 4, 5, -1};
      for (int i = 0; i < 3; i++)
         for (int c = 0; c < 4; c++) prv[i][c] = sx(base_rows[i][16*c +: 16]);
      for (int k = 0; k < 7; k++) begin
         th = off[k];
         if (src[k] >= 0) th += sx(j[src[k]]) * (64'sd1 <<< 18);
         sin_cos(th, ct, st);
         ca = (k == 3) ? 1 : 0;
         sa = (k == 3) ? 0 : ((k == 0 || k == 2 || k == 4) ? 1 : -1);
         d = 0;
         a = 0;
         if (k == 0) d = -link_len(sakj_pkg::LEN_2L2_Q);
         else if (k == 2) d = sat(sx(j[2]) - link_len(sakj_pkg::LEN_RCC_Q));
         else if (k == 3) d = link_len(sakj_pkg::LEN_TOOL_Q);
         else if (k == 6) d = -link_len(sakj_pkg::LEN_P2Y_Q);
         if (k == 5) a = link_len(sakj_pkg::LEN_P2Y_Q);
         lk[0] = '{ct, sat(-st), 0, a};
         lk[1] = '{sat(ca * st), sat(ca * ct), sat(-sa * 4096), sat(-sa * d)};
         lk[2] = '{sat(sa * st), sat(sa * ct), sat(ca * 4096), sat(ca * d)};
         for (int i = 0; i < 3; i++)
            for (int c = 0; c < 4; c++) begin
               acc = 0;
               for (int m = 0; m < 3; m++) acc += prv[i][m] * lk[m][c];
               if (c == 3) acc += prv[i][3] * 4096;
               tf[k][i][c] = sat(rnd(acc, 12));
            end
         prv = tf[k];
      end
      for (int k = 0; k < 7; k++) begin
         for (int i = 0; i < 3; i++) begin
            z[i] = tf[k][i][2];
            dv[i] = sat(tf[6][i][3] - tf[k][i][3]);
         end
         if (k == 2) begin
            lin = z;
            ang = '{0, 0, 0};
         end else begin
            lin[0] = sat(rnd(z[1] * dv[2] - z[2] * dv[1], 12));
            lin[1] = sat(rnd(z[2] * dv[0] - z[0] * dv[2], 12));
            lin[2] = sat(rnd(z[0] * dv[1] - z[1] * dv[0], 12));
            ang = z;
         end
         r.frame = 3'(k);
         r.row0 = {tf[k][0][3][15:0], tf[k][0][2][15:0], tf[k][0][1][15:0], tf[k][0][0][15:0]};
         r.row1 = {tf[k][1][3][15:0], tf[k][1][2][15:0], tf[k][1][1][15:0], tf[k][1][0][15:0]};
         r.row2 = {tf[k][2][3][15:0], tf[k][2][2][15:0], tf[k][2][1][15:0], tf[k][2][0][15:0]};
         r.lin = {lin[2][15:0], lin[1][15:0], lin[0][15:0]};
         r.ang = {ang[2][15:0], ang[1][15:0], ang[0][15:0]};
         r.last = (k == 6);
         pending.insert(pending.size(), r);
      end
   endfunction

   function void check_frame(frame_result_type got);
      frame_result_type w;
      frames_checked++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("Unexpected result item for frame %0d", got.frame);
         return;
      end
      w = pending.pop_front();
      if (got != w) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Mismatch: expected frame %0d rows %h %h %h lin %h ang %h last %b",
                     w.frame, w.row0, w.row1, w.row2, w.lin, w.ang, w.last);
            $display("          actual   frame %0d rows %h %h %h lin %h ang %h last %b",
                     got.frame, got.row0, got.row1, got.row2, got.lin, got.ang, got.last);
         end
      end
   endfunction
endclass

module testbench;
   import sakj_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [1:0] csr_index = CSR_BASE_ROW_ZERO;
   logic [63:0] csr_write_data = '0;
   logic req_valid = 0;
   logic req_ready;
   logic signed [15:0] joint_in[6] = '{default: '0};
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [2:0] rsp_frame_index;
   logic [63:0] rsp_frame_row_zero, rsp_frame_row_one, rsp_frame_row_two;
   logic [47:0] rsp_linear_column, rsp_angular_column;
   logic rsp_last_frame;

   kinematics_scoreboard board;
   int cycle_count = 0;
   int hold_off = 0;
   bit calm = 0;
   int joint_items = 0;

   serial_arm_kinematics_jacobian u_dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_outer_yaw(joint_in[0]), .req_outer_pitch(joint_in[1]),
      .req_insertion(joint_in[2]), .req_tool_roll(joint_in[3]),
      .req_wrist_pitch(joint_in[4]), .req_wrist_yaw(joint_in[5]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_frame_index(rsp_frame_index), .rsp_frame_row_zero(rsp_frame_row_zero),
      .rsp_frame_row_one(rsp_frame_row_one), .rsp_frame_row_two(rsp_frame_row_two),
      .rsp_linear_column(rsp_linear_column), .rsp_angular_column(rsp_angular_column),
      .rsp_last_frame(rsp_last_frame)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("serial_arm_kinematics_jacobian test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      frame_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.frame = rsp_frame_index;
         got.row0 = rsp_frame_row_zero;
         got.row1 = rsp_frame_row_one;
         got.row2 = rsp_frame_row_two;
         got.lin = rsp_linear_column;
         got.ang = rsp_angular_column;
         got.last = rsp_last_frame;
         board.check_frame(got);
      end
   end

   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 10);
      end
   end

   task automatic write_base(logic [1:0] idx, logic [63:0] v);
      @(negedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= v;
      board.set_base(idx, v);
      @(negedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic wait_drained();
      while (board.pending.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic send_joints(logic [15:0] j0, logic [15:0] j1, logic [15:0] j2,
                              logic [15:0] j3, logic [15:0] j4, logic [15:0] j5);
      logic [15:0] j[6];
      j = '{j0, j1, j2, j3, j4, j5};
      @(negedge clock);
      while (!calm && $urandom_range(99) < 10) @(negedge clock);
      req_valid <= 1;
      for (int i = 0; i < 6; i++) joint_in[i] <= j[i];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_joints(j);
      joint_items++;
      @(negedge clock);
      req_valid <= 0;
   endtask

   function automatic logic [15:0] rnd_joint(int sel);
      case (sel)
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(25736)) - 12868);
         default: return 16'($signed($urandom_range(8000)) - 4000);
      endcase
   endfunction

   function automatic logic [63:0] rnd_row(int r);
      logic [63:0] v;
      v = {$urandom, $urandom};
      if ($urandom_range(1)) begin
         v = '0;
         v[16*r +: 16] = 16'd4096;
         v[48 +: 16] = 16'($urandom);
      end
      return v;
   endfunction

   initial begin
      board = new();
      board.base_rows = '{64'h1000, 64'h1000_0000, 64'h1000_0000_0000};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      send_joints(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_joints(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_joints(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_joints(16'h3244, 16'hcdbc, 16'h6e8a, 16'h1922, 16'he6de, 16'h3244);
      send_joints(16'h1922, 16'h1922, 16'h0000, 16'hcdbc, 16'h1922, 16'he6de);
      send_joints(16'h5555, 16'haaaa, 16'h8000, 16'h5555, 16'haaaa, 16'hffff);
      wait_drained();

      write_base(CSR_BASE_ROW_ZERO, 64'h7fff_7fff_7fff_7fff);
      write_base(CSR_BASE_ROW_ONE, 64'h8000_8000_8000_8000);
      write_base(CSR_BASE_ROW_TWO, 64'h7fff_8000_7fff_8000);
      write_base(2'd3, 64'h1234_5678_9abc_def0);
      send_joints(16'h7fff, 16'h8000, 16'h7fff, 16'h0000, 16'h8000, 16'h7fff);
      send_joints(16'h0100, 16'hff00, 16'h8000, 16'h1000, 16'hf000, 16'h0000);
      wait_drained();

      // The receiver stalls for a long while so the block backs up.
      hold_off = 900;
      for (int n = 0; n < 3; n++)
         send_joints(rnd_joint(1), rnd_joint(1), rnd_joint(2), rnd_joint(1),
                     rnd_joint(1), rnd_joint(1));
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         for (int r = 0; r < 3; r++) write_base(r[1:0], rnd_row(r));
         calm = (phase == 2);
         for (int n = 0; n < 38; n++)
            send_joints(rnd_joint($urandom_range(2)), rnd_joint($urandom_range(2)),
                        rnd_joint($urandom_range(2)), rnd_joint($urandom_range(2)),
                        rnd_joint($urandom_range(2)), rnd_joint($urandom_range(2)));
         calm = 0;
         wait_drained();
      end

      $display("Sent %0d joint items over several base transforms; %0d frame items checked.",
               joint_items, board.frames_checked);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("serial_arm_kinematics_jacobian test passed");
      end else begin
         $display("serial_arm_kinematics_jacobian test failed");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
design/sakj_pkg.sv
design/sakj_controller.sv
design/sakj_datapath.sv
design/serial_arm_kinematics_jacobian.sv
sim/testbench.sv
